/* src/brsh_pkg.sv */
// Package for the block ring sample history: ring geometry, field widths,
// operation codes and configuration register indexes.
// No dependencies.
`default_nettype none

package brsh_pkg;

    // Ring geometry: BLOCK_TOTAL blocks of BLOCK_SAMPLES samples each.
    localparam int BLOCK_SAMPLES = 64;
    localparam int BLOCK_TOTAL   = 512;
    localparam int RING_SIZE     = BLOCK_SAMPLES * BLOCK_TOTAL;
    localparam int POS_W         = $clog2(BLOCK_SAMPLES);
    localparam int BLK_W         = $clog2(BLOCK_TOTAL);
    localparam int ADDR_W        = POS_W + BLK_W;

    // Field widths of the stream beats.
    localparam int MODE_W      = 2;
    localparam int ADC_W       = 12;
    localparam int SAMPLE_W    = 16;
    localparam int OFFSET_W    = 15;
    localparam int POSITION_W  = 6;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 40;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADC_MIDPOINT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CLAMP_NEGATIVE = CFG_INDEX_W'(1);
    localparam logic [ADC_W-1:0]       MIDPOINT_RESET     = ADC_W'(2048);

    // Operation selected by each input beat.
    typedef enum logic [MODE_W-1:0] {
        MODE_STORE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_ADVANCE = 2'd3
    } mode_t;

endpackage

`default_nettype wire

/* src/block_ring_sample_history.sv */
// Block ring sample history: a 32768 x 16 audio delay line held in one
// on-chip memory, with store, read, in-place write and read-block advance.
// Depends on brsh_pkg.
`default_nettype none

// Path: an input beat passes the input register, then the memory access
// with registered read data, to become its result beat.
// Throughput: one beat per cycle while the result side is ready; the memory
// does at most one write and one registered read per beat. After reset, a
// clearing pass zeroes all 32768 memory entries, one entry per cycle; no input
// beat is taken until it ends, while configuration writes are taken at once.
module block_ring_sample_history
    import brsh_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    // Configuration write channel.
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  wire                       s_tvalid,
    output logic                      s_tready,
    // s_tdata: adc_sample[11:0], processed_sample[27:12], sample_offset[42:28],
    //          block_position[48:43], zero fill [55:49]
    input  wire  [S_TDATA_W-1:0]      s_tdata,
    // s_tuser: mode[1:0]
    input  wire  [MODE_W-1:0]         s_tuser,
    // Result stream.
    output logic                      m_tvalid,
    input  wire                       m_tready,
    // m_tdata: read_value[15:0], write_block_now[24:16], read_block_now[33:25],
    //          zero fill [39:34]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(BLOCK_SAMPLES - 1);
    localparam logic [BLK_W-1:0]  BLK_LAST = BLK_W'(BLOCK_TOTAL - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(RING_SIZE - 1);

    // Configuration registers.
    logic [ADC_W-1:0]       adc_midpoint_reg;
    logic                   clamp_negative_reg;

    // Clearing pass.
    logic                   clear_busy_reg;
    logic [ADDR_W-1:0]      clear_addr_reg;

    // Input register stage.
    logic                   a_valid_reg;
    mode_t                  a_mode_reg;
    logic [ADC_W-1:0]       a_adc_reg;
    logic [SAMPLE_W-1:0]    a_processed_reg;
    logic [OFFSET_W-1:0]    a_offset_reg;
    logic [POSITION_W-1:0]  a_position_reg;

    // Ring pointers.
    logic [BLK_W-1:0]       write_block_reg;
    logic [BLK_W-1:0]       write_block_next;
    logic [POS_W-1:0]       write_position_reg;
    logic [POS_W-1:0]       write_position_next;
    logic [BLK_W-1:0]       read_block_reg;
    logic [BLK_W-1:0]       read_block_next;

    // Result register stage.
    logic                   m_valid_reg;
    logic                   b_is_read_reg;
    logic [BLK_W-1:0]       b_write_block_reg;
    logic [BLK_W-1:0]       b_read_block_reg;
    logic [SAMPLE_W-1:0]    rd_data_reg;

    // Memory and its port.
    logic [SAMPLE_W-1:0]    history_mem [RING_SIZE];
    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    logic [SAMPLE_W-1:0]    mem_wr_data;

    logic                   advance_b;
    logic                   fire_a;
    logic                   s_accept;
    logic [ADDR_W-1:0]      hist_addr;
    logic [ADDR_W-1:0]      store_addr;
    logic signed [ADC_W:0]  store_diff;
    logic [SAMPLE_W-1:0]    store_value;
    logic [SAMPLE_W-1:0]    read_value;

    // Handshake: the result stage moves when empty or taken downstream.
    assign advance_b = !m_valid_reg || m_tready;
    assign fire_a    = a_valid_reg && advance_b;
    assign s_tready  = !clear_busy_reg && (!a_valid_reg || advance_b);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_midpoint_reg   <= MIDPOINT_RESET;
            clamp_negative_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ADC_MIDPOINT) begin
                adc_midpoint_reg <= cfg_data;
            end else if (cfg_index == CFG_CLAMP_NEGATIVE) begin
                clamp_negative_reg <= cfg_data[0];
            end
        end
    end

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == CLR_LAST) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (fire_a) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_mode_reg      <= mode_t'(s_tuser);
            a_adc_reg       <= s_tdata[11:0];
            a_processed_reg <= s_tdata[27:12];
            a_offset_reg    <= s_tdata[42:28];
            a_position_reg  <= s_tdata[48:43];
        end
    end

    // Addresses and the stored ADC value.
    assign hist_addr  = {read_block_reg, POS_W'(0)} + ADDR_W'(a_position_reg)
                        - ADDR_W'(a_offset_reg);
    assign store_addr = {write_block_reg, write_position_reg};
    assign store_diff = $signed({1'b0, a_adc_reg}) - $signed({1'b0, adc_midpoint_reg});
    assign store_value = (clamp_negative_reg && store_diff[ADC_W]) ? '0 :
                         {{(SAMPLE_W - ADC_W - 1){store_diff[ADC_W]}}, store_diff};

    // Pointer updates and the memory write port.
    always_comb begin
        write_block_next    = write_block_reg;
        write_position_next = write_position_reg;
        read_block_next     = read_block_reg;
        mem_wr_en           = 1'b0;
        mem_wr_addr         = hist_addr;
        mem_wr_data         = a_processed_reg;
        if (clear_busy_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clear_addr_reg;
            mem_wr_data = '0;
        end else if (fire_a) begin
            case (a_mode_reg)
                MODE_STORE: begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = store_addr;
                    mem_wr_data = store_value;
                    if (write_position_reg == POS_LAST) begin
                        write_position_next = '0;
                        write_block_next    = (write_block_reg == BLK_LAST) ? '0 :
                                              write_block_reg + BLK_W'(1);
                    end else begin
                        write_position_next = write_position_reg + POS_W'(1);
                    end
                end
                MODE_WRITE: begin
                    mem_wr_en = 1'b1;
                end
                MODE_ADVANCE: begin
                    read_block_next = (read_block_reg == BLK_LAST) ? '0 :
                                      read_block_reg + BLK_W'(1);
                end
                default: begin
                    // A read leaves the pointers and memory unchanged.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_block_reg    <= '0;
            write_position_reg <= '0;
            read_block_reg     <= '0;
        end else begin
            write_block_reg    <= write_block_next;
            write_position_reg <= write_position_next;
            read_block_reg     <= read_block_next;
        end
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            history_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (fire_a) begin
            rd_data_reg <= history_mem[hist_addr];
        end
    end

    // Result register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance_b) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_a) begin
            b_is_read_reg     <= (a_mode_reg == MODE_READ);
            b_write_block_reg <= write_block_next;
            b_read_block_reg  <= read_block_next;
        end
    end

    assign read_value = b_is_read_reg ? rd_data_reg : '0;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {(M_TDATA_W - SAMPLE_W - 2 * BLK_W)'(0),
                         b_read_block_reg, b_write_block_reg, read_value};

    // No item may sit in the input stage while the memory is being cleared.
    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !a_valid_reg)
        else $error("input item present during clearing pass");

    // The last sample of a block returns the write position to the block start.
    a_write_position_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_a && a_mode_reg == MODE_STORE && write_position_reg == POS_LAST)
        |=> (write_position_reg == '0))
        else $error("write position did not wrap at end of block");

    // The read block moves only on an advance item.
    a_read_block_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire_a && a_mode_reg == MODE_ADVANCE) |=> $stable(read_block_reg))
        else $error("read block changed without an advance item");

    // Only a read result carries a nonzero sample.
    a_read_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !b_is_read_reg) |-> (m_tdata[SAMPLE_W-1:0] == '0))
        else $error("nonzero read value on a non-read result");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for block_ring_sample_history: directed and random
// stream traffic with a scoreboard fed by a behavioral model of the sample ring.
// Depends on brsh_pkg and the block_ring_sample_history RTL.

module tb;
    import brsh_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;

    // One input beat, split into its fields.
    typedef struct {
        mode_t                 mode;
        logic [ADC_W-1:0]      adc;
        logic [SAMPLE_W-1:0]   processed;
        logic [OFFSET_W-1:0]   offset;
        logic [POSITION_W-1:0] position;
    } sample_op_t;

    // One result beat, split into its fields.
    typedef struct {
        logic [SAMPLE_W-1:0] read_value;
        logic [BLK_W-1:0]    write_block_now;
        logic [BLK_W-1:0]    read_block_now;
    } ring_readout_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Model of the ring: sample store, pointers and register copies.
    logic [SAMPLE_W-1:0]    sample_hist [RING_SIZE];
    logic [BLK_W-1:0]       ring_wr_block;
    logic [POS_W-1:0]       ring_wr_pos;
    logic [BLK_W-1:0]       ring_rd_block;
    logic [ADC_W-1:0]       ring_midpoint;
    logic                   ring_clamp;
    logic [ADDR_W-1:0]      processed_addrs [$];

    ring_readout_t          pending_readouts [$];
    ring_readout_t          next_readout;
    int                     error_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     hold_left = 0;
    bit                     hold_request = 0;
    int                     cycle_count = 0;

    always #1 aclk = ~aclk;

    block_ring_sample_history dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic sample_op_t op_of(mode_t mode, logic [ADC_W-1:0] adc,
                                         logic [SAMPLE_W-1:0] processed,
                                         logic [OFFSET_W-1:0] offset,
                                         logic [POSITION_W-1:0] position);
        sample_op_t op;
        op.mode      = mode;
        op.adc       = adc;
        op.processed = processed;
        op.offset    = offset;
        op.position  = position;
        return op;
    endfunction

    // History address for reads and in-place writes, wrapping around the ring.
    function automatic logic [ADDR_W-1:0] history_addr(sample_op_t op);
        return {ring_rd_block, POS_W'(0)} + ADDR_W'(op.position) - ADDR_W'(op.offset);
    endfunction

    // Offset that makes a read or write at this position hit the given address.
    function automatic logic [OFFSET_W-1:0] offset_to(logic [ADDR_W-1:0] target,
                                                      logic [POSITION_W-1:0] position);
        return OFFSET_W'({ring_rd_block, POS_W'(0)} + ADDR_W'(position) - target);
    endfunction

    // Apply one accepted beat to the ring model and queue the result it gives.
    function automatic void ring_predict(sample_op_t op);
        ring_readout_t     r;
        logic [ADDR_W-1:0] addr;
        int                s;
        r.read_value = '0;
        addr = history_addr(op);
        case (op.mode)
            MODE_STORE: begin
                s = int'(op.adc) - int'(ring_midpoint);
                if (ring_clamp && s < 0) begin
                    s = 0;
                end
                sample_hist[{ring_wr_block, ring_wr_pos}] = SAMPLE_W'(s);
                ring_wr_pos = ring_wr_pos + 1'b1;
                if (ring_wr_pos == '0) begin
                    ring_wr_block = ring_wr_block + 1'b1;
                end
            end
            MODE_READ: begin
                r.read_value = sample_hist[addr];
            end
            MODE_WRITE: begin
                sample_hist[addr] = op.processed;
                processed_addrs.push_back(addr);
                if (processed_addrs.size() > 16) begin
                    void'(processed_addrs.pop_front());
                end
            end
            default: begin
                ring_rd_block = ring_rd_block + 1'b1;
            end
        endcase
        r.write_block_now = ring_wr_block;
        r.read_block_now  = ring_rd_block;
        pending_readouts.push_back(r);
    endfunction

    // Mostly aim at recently stored or rewritten samples; some fully random.
    function automatic logic [ADDR_W-1:0] pick_target();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return {ring_wr_block, ring_wr_pos} - ADDR_W'($urandom_range(320, 1));
        end else if (r < 80 && processed_addrs.size() > 0) begin
            return processed_addrs[$urandom_range(processed_addrs.size() - 1)];
        end
        return ADDR_W'($urandom);
    endfunction

    function automatic sample_op_t random_op();
        sample_op_t op;
        int         r;
        r = $urandom_range(99);
        if (r < 35) begin
            op.mode = MODE_STORE;
        end else if (r < 70) begin
            op.mode = MODE_READ;
        end else if (r < 85) begin
            op.mode = MODE_WRITE;
        end else begin
            op.mode = MODE_ADVANCE;
        end
        op.adc       = ADC_W'($urandom);
        op.processed = SAMPLE_W'($urandom);
        if ($urandom_range(9) == 0) begin
            op.adc       = $urandom_range(1) ? '1 : '0;
            op.processed = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        op.position = POSITION_W'($urandom);
        op.offset   = offset_to(pick_target(), op.position);
        return op;
    endfunction

    // Offer one beat, with random idle cycles first, and model it once taken.
    task automatic send_sample_op(sample_op_t op);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.mode;
        s_tdata  <= {7'b0, op.position, op.offset, op.processed, op.adc};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        ring_predict(op);
    endtask

    // Stop offering beats and let every outstanding result come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        if (index == CFG_ADC_MIDPOINT) begin
            ring_midpoint = data;
        end else if (index == CFG_CLAMP_NEGATIVE) begin
            ring_clamp = data[0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] midpoint, logic [CFG_DATA_W-1:0] clamp);
        wait_idle();
        write_register(CFG_ADC_MIDPOINT, midpoint);
        write_register(CFG_CLAMP_NEGATIVE, clamp);
    endtask

    // Field extremes, every mode, and address wrap from the bottom of the ring to its top.
    task automatic test_directed_ops();
        send_sample_op(op_of(MODE_STORE, 12'd0, 16'h1234, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd4095, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd2048, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd0, 6'd1));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd0, 6'd63));
        // An offset past the block start reaches back to the top of the ring.
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd1, 6'd0));
        send_sample_op(op_of(MODE_WRITE, 12'd0, 16'h8000, 15'd1, 6'd0));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd1, 6'd0));
        // Largest offset together with the largest position.
        send_sample_op(op_of(MODE_WRITE, 12'hFFF, 16'h7FFF, 15'h7FFF, 6'd63));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'h7FFF, 6'd0));
        send_sample_op(op_of(MODE_WRITE, 12'd0, 16'hFFFF, 15'd3, 6'd5));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd3, 6'd5));
        send_sample_op(op_of(MODE_ADVANCE, 12'hFFF, 16'hFFFF, 15'h7FFF, 6'd63));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_READ, 12'd0, 16'h0, 15'd65, 6'd0));
        send_sample_op(op_of(MODE_ADVANCE, 12'd0, 16'h0, 15'd0, 6'd0));
    endtask

    // Midpoint and clamp at their extremes, then read the last four stored samples back.
    task automatic test_config_extremes();
        logic [POSITION_W-1:0] pos;
        configure(12'd0, 12'd0);
        send_sample_op(op_of(MODE_STORE, 12'd4095, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd0, 16'h0, 15'd0, 6'd0));
        configure(12'd4095, 12'd0);
        send_sample_op(op_of(MODE_STORE, 12'd0, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd4095, 16'h0, 15'd0, 6'd0));
        configure(12'd4095, 12'hFFF);
        send_sample_op(op_of(MODE_STORE, 12'd0, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd4095, 16'h0, 15'd0, 6'd0));
        configure(12'd100, 12'h001);
        send_sample_op(op_of(MODE_STORE, 12'd99, 16'h0, 15'd0, 6'd0));
        // Only bit 0 of the clamp register counts.
        configure(12'd100, 12'hFFE);
        send_sample_op(op_of(MODE_STORE, 12'd99, 16'h0, 15'd0, 6'd0));
        send_sample_op(op_of(MODE_STORE, 12'd4095, 16'h0, 15'd0, 6'd0));
        for (int k = 1; k <= 4; k++) begin
            pos = POSITION_W'($urandom);
            send_sample_op(op_of(MODE_READ, 12'd0, 16'h0,
                                 offset_to({ring_wr_block, ring_wr_pos} - ADDR_W'(k), pos),
                                 pos));
        end
    endtask

    task automatic test_random_traffic(int count);
        for (int k = 0; k < count; k++) begin
            send_sample_op(random_op());
        end
    endtask

    // Advance the read block past the end of the ring, with reads in between.
    task automatic test_read_block_wrap();
        sample_op_t op;
        int         remaining;
        remaining = BLOCK_TOTAL - int'(ring_rd_block) + 6;
        while (remaining > 0) begin
            op = random_op();
            if ($urandom_range(3) == 0) begin
                op.mode = MODE_READ;
            end else begin
                op.mode = MODE_ADVANCE;
                remaining--;
            end
            send_sample_op(op);
        end
    endtask

    // Hold the result side off for a long stretch while beats keep coming.
    task automatic test_output_stall();
        hold_request = 1'b1;
        test_random_traffic(48);
    endtask

    // Result side ready: random stalls, plus a long hold on request.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result beat with the oldest predicted readout.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readouts.size() == 0) begin
                note_failure($sformatf("unexpected result beat %h", m_tdata));
            end else begin
                next_readout = pending_readouts.pop_front();
                if (m_tdata[15:0] !== next_readout.read_value) begin
                    note_failure($sformatf("read_value: expected %0d, got %0d",
                                           $signed(next_readout.read_value),
                                           $signed(m_tdata[15:0])));
                end
                if (m_tdata[24:16] !== next_readout.write_block_now) begin
                    note_failure($sformatf("write_block_now: expected %0d, got %0d",
                                           next_readout.write_block_now, m_tdata[24:16]));
                end
                if (m_tdata[33:25] !== next_readout.read_block_now) begin
                    note_failure($sformatf("read_block_now: expected %0d, got %0d",
                                           next_readout.read_block_now, m_tdata[33:25]));
                end
            end
        end
    end

    // Run limit, which also covers the memory clearing pass after reset.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[block_ring_sample_history] ERROR");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_STORE;
        for (int i = 0; i < RING_SIZE; i++) begin
            sample_hist[i] = '0;
        end
        ring_wr_block = '0;
        ring_wr_pos   = '0;
        ring_rd_block = '0;
        ring_midpoint = MIDPOINT_RESET;
        ring_clamp    = 1'b0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Sender mostly busy, receiver stalling often.
        tx_idle_pct = 6;
        rx_idle_pct = 68;
        test_directed_ops();
        test_config_extremes();
        configure(CFG_DATA_W'($urandom_range(4095)), 12'd0);
        test_random_traffic(250);

        // Sender idling often, receiver mostly ready.
        tx_idle_pct = 68;
        rx_idle_pct = 6;
        configure(CFG_DATA_W'($urandom_range(4095)), {11'($urandom), 1'b1});
        test_random_traffic(250);

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(12'd2048, 12'd0);
        test_random_traffic(200);
        test_read_block_wrap();
        test_output_stall();

        wait_idle();
        if (pending_readouts.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_readouts.size()));
        end
        if (error_count == 0) begin
            $display("[block_ring_sample_history] OK");
        end else begin
            $display("[block_ring_sample_history] ERROR");
        end
        $finish;
    end

endmodule
